>>> hdl/http_request_head_parser_unit_assert.svh
// Assertion macros shared by the parser modules.
// Each macro takes a label, a property expression and a message string.
// The clocked forms sample on clk; the guarded form is disabled while rst is high.
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define HRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRP_ASSERT(lbl, prop, msg)
`define HRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/hrp_pkg.sv
`timescale 1ns / 1ps

package hrp_pkg;

  // Result kinds.
  localparam logic [2:0] K_METHOD   = 3'd0;
  localparam logic [2:0] K_PATH     = 3'd1;
  localparam logic [2:0] K_NAME     = 3'd2;
  localparam logic [2:0] K_VALUE    = 3'd3;
  localparam logic [2:0] K_HDONE    = 3'd4;
  localparam logic [2:0] K_HEAD_END = 3'd5;
  localparam logic [2:0] K_BODY     = 3'd6;
  localparam logic [2:0] K_ERROR    = 3'd7;

  // Parse phases.
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_HNAME   = 3'd3;
  localparam logic [2:0] PH_HSKIP   = 3'd4;
  localparam logic [2:0] PH_HVALUE  = 3'd5;
  localparam logic [2:0] PH_BODY    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // Special characters.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Request line limit register.
  localparam int         LIMIT_W     = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // Method table: names packed first character in the low byte.
  localparam int         N_METHODS   = 9;
  localparam logic [3:0] METHOD_NONE = 4'd9;
  localparam logic [63:0] METHOD_PACKED [N_METHODS] = '{
    64'h0000_0000_0054_4547,   // GET
    64'h0000_0000_5453_4F50,   // POST
    64'h0000_0000_0054_5550,   // PUT
    64'h0000_4554_454C_4544,   // DELETE
    64'h0000_0000_4441_4548,   // HEAD
    64'h0053_4E4F_4954_504F,   // OPTIONS
    64'h0000_0045_4341_5254,   // TRACE
    64'h0054_4345_4E4E_4F43,   // CONNECT
    64'h0000_0048_4354_4150    // PATCH
  };
  localparam logic [3:0] METHOD_LEN [N_METHODS] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd7, 4'd5
  };

  // Output queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One result item.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] method_code;
    logic       last;
  } res_t;

  // Results produced by one byte, handed to the output queue.
  typedef struct packed {
    logic [1:0]       n;
    res_t [1:0]       res;
  } push_t;

endpackage

>>> hdl/http_request_head_parser_unit.sv
`timescale 1ns / 1ps
// Flow: a byte accepted into the input register is parsed, and its results are written
// into the output queue, from which they are offered.
// Throughput: one byte per cycle while the queue has room; a byte that yields two results takes
// two entries of the four-entry output queue, and input stalls while fewer than two slots are free.
// Reset (rst, synchronous): parse state to the method phase, queue empty, line limit 1024.

module http_request_head_parser_unit import hrp_pkg::*; #(
  parameter int MAX_METHOD_LEN = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               first_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [7:0]         data,
  output logic [3:0]         method_code,
  output logic               last,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  push_t push;
  logic  room;
  res_t  head;

  // Parser step with its input register and state.
  hrp_core #(
    .MAX_METHOD_LEN(MAX_METHOD_LEN)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .first_byte (first_byte),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .room       (room),
    .push       (push)
  );

  // Result queue toward the output channel.
  hrp_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign kind        = head.kind;
  assign data        = head.data;
  assign method_code = head.method_code;
  assign last        = head.last;

endmodule

>>> hdl/hrp_core.sv
`timescale 1ns / 1ps
`include "http_request_head_parser_unit_assert.svh"

module hrp_core import hrp_pkg::*; #(
  parameter int MAX_METHOD_LEN = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               first_byte,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               room,
  output push_t              push
);

  localparam int MC_W = $clog2(MAX_METHOD_LEN + 1);
  localparam int CH_W = 8 * MAX_METHOD_LEN;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       fire;

  // Parse state.
  logic [2:0]         phase, phase_next;
  logic [CH_W-1:0]    method_chars, method_chars_next;
  logic [MC_W-1:0]    method_count, method_count_next;
  logic               method_too_long, method_too_long_next;
  logic [LIMIT_W-1:0] line_bytes, line_bytes_next;
  logic               cr_pending, cr_pending_next;
  logic               name_seen, name_seen_next;
  logic               value_seen, value_seen_next;
  logic [LIMIT_W-1:0] request_line_limit;

  // Results of the current byte, in order.
  logic       ra_v, rb_v;
  res_t       ra, rb;
  logic       abort;
  logic [1:0] n;

  // Returns the method code, or METHOD_NONE when no name matches.
  function automatic logic [3:0] match_method(input logic [CH_W-1:0] ch,
                                              input logic [MC_W-1:0] cnt,
                                              input logic tl);
    logic [3:0] code;
    code = METHOD_NONE;
    if (!tl && cnt != '0) begin
      for (int m = N_METHODS - 1; m >= 0; m--) begin
        if (64'(ch) == METHOD_PACKED[m] && 4'(cnt) == METHOD_LEN[m]) begin
          code = 4'(m);
        end
      end
    end
    return code;
  endfunction

  // One ordinary data byte (not part of a line end).
  function automatic void take_data(input logic [7:0] b,
                                    inout logic [2:0] ph,
                                    inout logic [CH_W-1:0] ch,
                                    inout logic [MC_W-1:0] cnt,
                                    inout logic tl,
                                    inout logic ns,
                                    inout logic vs,
                                    output logic rv,
                                    output res_t r);
    logic [3:0] code;
    code = match_method(ch, cnt, tl);
    rv = 1'b0;
    r  = '0;
    unique case (ph)
      PH_METHOD: begin
        if (b == CH_SP) begin
          rv = 1'b1;
          if (code == METHOD_NONE) begin
            r.kind = K_ERROR;
            ph = PH_ERROR;
          end else begin
            r.kind = K_METHOD;
            r.method_code = code;
            ph = PH_PATH;
          end
        end else if (cnt < MC_W'(MAX_METHOD_LEN)) begin
          ch[8*cnt +: 8] = ch[8*cnt +: 8] | b;
          cnt = cnt + MC_W'(1);
        end else begin
          tl = 1'b1;
        end
      end
      PH_PATH: begin
        if (b == CH_SP) begin
          ph = PH_VERSION;
        end else begin
          rv = 1'b1;
          r.kind = K_PATH;
          r.data = b;
        end
      end
      PH_HNAME: begin
        if (b == CH_COLON) begin
          if (!ns) begin
            rv = 1'b1;
            r.kind = K_ERROR;
            ph = PH_ERROR;
          end else begin
            ph = PH_HSKIP;
          end
        end else begin
          rv = 1'b1;
          r.kind = K_NAME;
          r.data = b;
          ns = 1'b1;
        end
      end
      PH_HSKIP: begin
        ph = PH_HVALUE;
      end
      PH_HVALUE: begin
        rv = 1'b1;
        r.kind = K_VALUE;
        r.data = b;
        vs = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // Input handshake: the register holds while the queue lacks room for two results.
  assign fire     = s1_valid && room;
  assign in_stall = s1_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= rx_byte;
      s1_first <= first_byte;
    end
  end

  // Per-byte parse step.
  always_comb begin
    if (s1_first) begin
      phase_next           = PH_METHOD;
      method_chars_next    = '0;
      method_count_next    = '0;
      method_too_long_next = 1'b0;
      line_bytes_next      = '0;
      cr_pending_next      = 1'b0;
      name_seen_next       = 1'b0;
      value_seen_next      = 1'b0;
    end else begin
      phase_next           = phase;
      method_chars_next    = method_chars;
      method_count_next    = method_count;
      method_too_long_next = method_too_long;
      line_bytes_next      = line_bytes;
      cr_pending_next      = cr_pending;
      name_seen_next       = name_seen;
      value_seen_next      = value_seen;
    end
    ra_v  = 1'b0;
    ra    = '0;
    rb_v  = 1'b0;
    rb    = '0;
    abort = 1'b0;

    if (phase_next == PH_ERROR) begin
      // Sticky error: no results until the next request starts.
    end else if (phase_next == PH_BODY) begin
      ra_v    = 1'b1;
      ra.kind = K_BODY;
      ra.data = s1_byte;
    end else if (cr_pending_next && s1_byte == CH_LF) begin
      // Line end.
      cr_pending_next = 1'b0;
      unique case (phase_next)
        PH_VERSION: begin
          phase_next      = PH_HNAME;
          name_seen_next  = 1'b0;
          value_seen_next = 1'b0;
        end
        PH_HNAME: begin
          ra_v = 1'b1;
          if (name_seen_next) begin
            ra.kind    = K_ERROR;
            phase_next = PH_ERROR;
          end else begin
            ra.kind    = K_HEAD_END;
            phase_next = PH_BODY;
          end
        end
        PH_HVALUE: begin
          ra_v = 1'b1;
          if (value_seen_next) begin
            ra.kind         = K_HDONE;
            phase_next      = PH_HNAME;
            name_seen_next  = 1'b0;
            value_seen_next = 1'b0;
          end else begin
            ra.kind    = K_ERROR;
            phase_next = PH_ERROR;
          end
        end
        default: begin
          ra_v       = 1'b1;
          ra.kind    = K_ERROR;
          phase_next = PH_ERROR;
        end
      endcase
    end else begin
      // Request line bytes count against the limit, saturating.
      if (phase_next <= PH_VERSION) begin
        if (line_bytes_next != '1) begin
          line_bytes_next = line_bytes_next + LIMIT_W'(1);
        end
        if (line_bytes_next >= request_line_limit) begin
          ra_v            = 1'b1;
          ra.kind         = K_ERROR;
          phase_next      = PH_ERROR;
          cr_pending_next = 1'b0;
          abort           = 1'b1;
        end
      end
      if (!abort) begin
        // A CR that was not followed by LF is plain data.
        if (cr_pending_next) begin
          cr_pending_next = 1'b0;
          take_data(CH_CR, phase_next, method_chars_next, method_count_next,
                    method_too_long_next, name_seen_next, value_seen_next, ra_v, ra);
        end
        if (phase_next != PH_ERROR) begin
          if (s1_byte == CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            take_data(s1_byte, phase_next, method_chars_next, method_count_next,
                      method_too_long_next, name_seen_next, value_seen_next, rb_v, rb);
          end
        end
      end
    end
  end

  // Pack the results in order and mark the final one.
  always_comb begin
    n = {1'b0, ra_v} + {1'b0, rb_v};
    push.res[0] = ra_v ? ra : rb;
    push.res[1] = rb;
    push.res[0].last = (n == 2'd1);
    push.res[1].last = 1'b1;
    push.n = fire ? n : 2'd0;
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_METHOD;
      method_chars    <= '0;
      method_count    <= '0;
      method_too_long <= 1'b0;
      line_bytes      <= '0;
      cr_pending      <= 1'b0;
      name_seen       <= 1'b0;
      value_seen      <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      method_chars    <= method_chars_next;
      method_count    <= method_count_next;
      method_too_long <= method_too_long_next;
      line_bytes      <= line_bytes_next;
      cr_pending      <= cr_pending_next;
      name_seen       <= name_seen_next;
      value_seen      <= value_seen_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      request_line_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      request_line_limit <= cfg_wr_data;
    end
  end

  `HRP_ASSERT(a_error_silent, fire && phase == PH_ERROR && !s1_first |-> push.n == 2'd0, "result after error")
  `HRP_ASSERT(a_two_need_cr, fire && push.n == 2'd2 |-> cr_pending && !s1_first, "two results without lone CR")
  `HRP_ASSERT(a_body_sticky, fire && phase == PH_BODY && !s1_first |=> phase == PH_BODY, "left body phase")

endmodule

>>> hdl/hrp_out_queue.sv
`timescale 1ns / 1ps
`include "http_request_head_parser_unit_assert.svh"

module hrp_out_queue import hrp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  head
);

  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  res_t            slots [Q_DEPTH];
  logic            pop;

  // Room means two free slots, enough for the worst case of one byte.
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= Q_CW'(Q_DEPTH - 2));
  assign head      = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.n);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count + Q_CW'(push.n) - Q_CW'(pop);
    end
  end

  // Up to two results are written per cycle.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.res[0];
    end
    if (push.n == 2'd2) begin
      slots[wr_ptr + Q_AW'(1)] <= push.res[1];
    end
  end

  `HRP_ASSERT(a_count_bound, count <= Q_CW'(Q_DEPTH), "queue overfilled")
  `HRP_ASSERT(a_push_room, push.n != 2'd0 |-> count <= Q_CW'(Q_DEPTH - 2), "push without room")
  `HRP_ASSERT_ALWAYS(a_count_track, !rst && !$past(rst) |-> count == $past(count) + Q_CW'($past(push.n)) - Q_CW'($past(pop)), "fill count mismatch")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hrp_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          METHOD_MAX     = 7;
  localparam logic [10:0] LINE_LIMIT_RST = 11'd1024;
  localparam int          HOLD_CYCLES    = 120;
  localparam int          SHOWN_ERRORS   = 40;

  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] COLON = 8'h3A;
  localparam logic [7:0] CR    = 8'h0D;
  localparam logic [7:0] LF    = 8'h0A;

  // Parser phases as the predictor tracks them.
  typedef enum logic [2:0] {
    P_METHOD, P_PATH, P_VERSION, P_HNAME, P_HSKIP, P_HVALUE, P_BODY, P_ERROR
  } parse_phase_e;

  typedef enum logic [3:0] {
    M_GET, M_POST, M_PUT, M_DELETE, M_HEAD, M_OPTIONS, M_TRACE, M_CONNECT, M_PATCH,
    M_NONE
  } method_e;

  // Ways in which a generated request may be broken.
  typedef enum int {
    CLEAN, BAD_METHOD, NO_COLON, EMPTY_NAME, EMPTY_VALUE, SHORT_LINE, CUT_SHORT, NOISE
  } flaw_e;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
  } stream_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              first_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        kind;
  logic [7:0]        data;
  logic [3:0]        method_code;
  logic              last;
  logic              cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;

  http_request_head_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .first_byte  (first_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data        (data),
    .method_code (method_code),
    .last        (last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Predictor state for the parser.
  parse_phase_e phase;
  logic [55:0]  method_bytes;
  int           method_len;
  bit           method_long;
  logic [10:0]  line_count;
  logic [10:0]  line_limit;
  bit           cr_wait;
  bit           name_seen;
  bit           value_seen;
  res_t         step_out [2];
  int           step_n;

  res_t         expected_results [$];
  stream_byte_t byte_queue [$];
  stream_byte_t request_bytes [$];
  stream_byte_t next_byte;
  res_t         want;
  bit           first_pending;

  int idle_pct = 34;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle = 0;
  int errors = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int requests_made = 0;
  int limits_written = 0;
  int kind_hits [8];

  function automatic string method_name(input method_e m);
    case (m)
      M_GET:     return "GET";
      M_POST:    return "POST";
      M_PUT:     return "PUT";
      M_DELETE:  return "DELETE";
      M_HEAD:    return "HEAD";
      M_OPTIONS: return "OPTIONS";
      M_TRACE:   return "TRACE";
      M_CONNECT: return "CONNECT";
      M_PATCH:   return "PATCH";
      default:   return "";
    endcase
  endfunction

  function automatic void clear_parse();
    phase        = P_METHOD;
    method_bytes = '0;
    method_len   = 0;
    method_long  = 1'b0;
    line_count   = '0;
    cr_wait      = 1'b0;
    name_seen    = 1'b0;
    value_seen   = 1'b0;
  endfunction

  // A byte gives at most two results; any beyond that are dropped.
  function automatic void emit(input logic [2:0] k, input logic [7:0] d, input logic [3:0] c);
    if (step_n < 2) begin
      step_out[step_n].kind        = k;
      step_out[step_n].data        = d;
      step_out[step_n].method_code = c;
      step_out[step_n].last        = 1'b0;
      step_n++;
    end
  endfunction

  function automatic void raise_error();
    emit(K_ERROR, 8'h00, 4'd0);
    phase   = P_ERROR;
    cr_wait = 1'b0;
  endfunction

  function automatic method_e lookup_method();
    string       name;
    logic [55:0] packed_name;
    method_e     found;
    found = M_NONE;
    if (!method_long && method_len != 0) begin
      for (int m = M_GET; m <= M_PATCH; m++) begin
        name = method_name(method_e'(m));
        packed_name = '0;
        for (int i = 0; i < name.len(); i++) packed_name[8*i +: 8] = name[i];
        if (name.len() == method_len && packed_name == method_bytes) found = method_e'(m);
      end
    end
    return found;
  endfunction

  // An ordinary byte of the current line.
  function automatic void take_data(input logic [7:0] b);
    method_e code;
    case (phase)
      P_METHOD: begin
        if (b == SPACE) begin
          code = lookup_method();
          if (code == M_NONE) begin
            raise_error();
          end else begin
            emit(K_METHOD, 8'h00, code);
            phase = P_PATH;
          end
        end else if (method_len < METHOD_MAX) begin
          method_bytes[8*method_len +: 8] = b;
          method_len++;
        end else begin
          method_long = 1'b1;
        end
      end
      P_PATH: begin
        if (b == SPACE) phase = P_VERSION;
        else emit(K_PATH, b, 4'd0);
      end
      P_HNAME: begin
        if (b == COLON) begin
          if (!name_seen) raise_error();
          else phase = P_HSKIP;
        end else begin
          emit(K_NAME, b, 4'd0);
          name_seen = 1'b1;
        end
      end
      P_HSKIP: phase = P_HVALUE;
      P_HVALUE: begin
        emit(K_VALUE, b, 4'd0);
        value_seen = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // A complete CR LF pair.
  function automatic void take_line_end();
    case (phase)
      P_VERSION: begin
        phase      = P_HNAME;
        name_seen  = 1'b0;
        value_seen = 1'b0;
      end
      P_HNAME: begin
        if (name_seen) begin
          raise_error();
        end else begin
          emit(K_HEAD_END, 8'h00, 4'd0);
          phase = P_BODY;
        end
      end
      P_HVALUE: begin
        if (value_seen) begin
          emit(K_HDONE, 8'h00, 4'd0);
          phase      = P_HNAME;
          name_seen  = 1'b0;
          value_seen = 1'b0;
        end else begin
          raise_error();
        end
      end
      default: raise_error();
    endcase
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void parse_byte(input logic [7:0] b, input logic first);
    bit aborted;
    step_n = 0;
    if (first) clear_parse();
    if (phase == P_ERROR) begin
      // Sticky error: nothing more until the next request starts.
    end else if (phase == P_BODY) begin
      emit(K_BODY, b, 4'd0);
    end else if (cr_wait && b == LF) begin
      cr_wait = 1'b0;
      take_line_end();
    end else begin
      aborted = 1'b0;
      if (phase <= P_VERSION) begin
        if (line_count < 11'd2047) line_count++;
        if (line_count >= line_limit) begin
          raise_error();
          aborted = 1'b1;
        end
      end
      if (!aborted) begin
        // A held CR that is not part of a line end is plain data.
        if (cr_wait) begin
          cr_wait = 1'b0;
          take_data(CR);
        end
        if (phase != P_ERROR) begin
          if (b == CR) cr_wait = 1'b1;
          else take_data(b);
        end
      end
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_results.push_back(step_out[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("MISMATCH at cycle %0d: %s", cycle, msg);
  endtask

  // Cycle count and the run's time limit.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still due", cycle,
               expected_results.size());
      $display("http_request_head_parser_unit test failed");
      $finish;
    end
  end

  // Sender: offers queued bytes and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(rx_byte, first_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_byte = byte_queue.pop_front();
          in_valid   <= 1'b1;
          rx_byte    <= next_byte.value;
          first_byte <= next_byte.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  // Checker: each taken result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      kind_hits[kind]++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing due: kind %0d data %02h code %0d",
                                  kind, data, method_code));
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (data !== want.data)
          report_mismatch($sformatf("data %02h, expected %02h (kind %0d)", data, want.data,
                                    want.kind));
        if (method_code !== want.method_code)
          report_mismatch($sformatf("method_code %0d, expected %0d", method_code,
                                    want.method_code));
        if (last !== want.last)
          report_mismatch($sformatf("last %0d, expected %0d (kind %0d)", last, want.last,
                                    want.kind));
      end
    end
  end

  // Request building: bytes collect in request_bytes and then go to the sender.
  task automatic queue_byte(input logic [7:0] b);
    stream_byte_t item;
    item.value    = b;
    item.first    = first_pending;
    first_pending = 1'b0;
    request_bytes.push_back(item);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_crlf();
    queue_byte(CR);
    queue_byte(LF);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == SPACE || b == COLON || b == CR || b == LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Field text, now and then with a lone CR inside.
  task automatic queue_field(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) queue_byte(CR);
      queue_byte(plain_byte());
    end
  endtask

  task automatic flush_request(input int keep);
    for (int i = 0; i < keep && i < request_bytes.size(); i++) begin
      byte_queue.push_back(request_bytes[i]);
      bytes_queued++;
    end
    request_bytes.delete();
  endtask

  task automatic queue_request();
    flaw_e flaw;
    int    n_headers;
    int    bad_header;
    int    len;
    request_bytes.delete();
    first_pending = 1'b1;
    requests_made++;
    flaw = ($urandom_range(0, 99) < 72) ? CLEAN : flaw_e'($urandom_range(1, 7));
    if (flaw == NOISE) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        first_pending = 1'($urandom_range(0, 1));
        queue_byte(8'($urandom_range(0, 255)));
      end
      flush_request(request_bytes.size());
      return;
    end
    // Request line.
    if (flaw == BAD_METHOD) begin
      len = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(65, 90)));
    end else begin
      queue_text(method_name(method_e'($urandom_range(M_GET, M_PATCH))));
    end
    queue_byte(SPACE);
    queue_field($urandom_range(0, 6));
    if (flaw == SHORT_LINE) begin
      queue_crlf();
      flush_request(request_bytes.size());
      return;
    end
    queue_byte(SPACE);
    if ($urandom_range(0, 1)) queue_text("HTTP/1.1");
    else queue_field($urandom_range(0, 3));
    queue_crlf();
    // Header lines.
    n_headers = $urandom_range(0, 3);
    bad_header = -1;
    if (flaw == NO_COLON || flaw == EMPTY_NAME || flaw == EMPTY_VALUE) begin
      if (n_headers == 0) n_headers = 1;
      bad_header = $urandom_range(0, n_headers - 1);
    end
    for (int h = 0; h < n_headers; h++) begin
      if (!(h == bad_header && flaw == EMPTY_NAME)) queue_field($urandom_range(1, 6));
      if (h == bad_header && flaw == NO_COLON) begin
        queue_crlf();
        continue;
      end
      queue_byte(COLON);
      queue_byte($urandom_range(0, 3) != 0 ? SPACE : plain_byte());
      if (!(h == bad_header && flaw == EMPTY_VALUE)) queue_field($urandom_range(1, 8));
      queue_crlf();
    end
    queue_crlf();
    // Body bytes pass through untouched, so any value goes.
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
    if (flaw == CUT_SHORT) flush_request($urandom_range(1, request_bytes.size()));
    else flush_request(request_bytes.size());
  endtask

  task automatic queue_requests(input int n_bytes);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) queue_request();
  endtask

  // Waits until every byte is taken and every result is in, then lets the block settle.
  task automatic wait_quiet();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_limit(input logic [10:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    line_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limits_written++;
  endtask

  task automatic queue_directed();
    // Extreme path bytes, empty version, blank line right after the request line.
    first_pending = 1'b1;
    queue_text("GET ");
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(SPACE);
    queue_crlf();
    queue_crlf();
    // Empty method, then a byte that the sticky error swallows.
    first_pending = 1'b1;
    queue_byte(SPACE);
    queue_byte(8'h5A);
    // Line end while still in the method.
    first_pending = 1'b1;
    queue_byte(8'h41);
    queue_crlf();
    // Lone CR in the path.
    first_pending = 1'b1;
    queue_text("PUT ");
    queue_byte(CR);
    queue_byte(8'h7F);
    flush_request(request_bytes.size());
  endtask

  // Test sequence.
  initial begin
    int drain;
    for (int k = 0; k < 8; k++) kind_hits[k] = 0;
    clear_parse();
    line_limit = LINE_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the limit, with random idling on both sides.
    queue_directed();
    queue_requests(140);
    wait_quiet();

    // Largest limit, both sides running flat out.
    write_line_limit(11'd2047);
    idle_pct = 0;
    queue_requests(150);
    wait_quiet();

    // Tight limit so long request lines fail; receiver holds off to back up the input.
    idle_pct = 34;
    write_line_limit(11'd18);
    hold_requests++;
    queue_requests(150);
    wait_quiet();

    // Smallest limits: every request line fails at once.
    write_line_limit(11'd1);
    queue_requests(20);
    wait_quiet();
    write_line_limit(11'd0);
    queue_requests(20);
    wait_quiet();

    // Random limits.
    write_line_limit(11'($urandom_range(8, 40)));
    queue_requests(140);
    wait_quiet();
    write_line_limit(11'($urandom_range(1, 2047)));
    queue_requests(120);

    // Final drain.
    while (bytes_taken != bytes_queued) @(posedge clk);
    drain = 0;
    while (expected_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never came out",
                                expected_results.size()));

    $display("Run covered %0d bytes in %0d requests under %0d limit writes; %0d results.",
             bytes_taken, requests_made, limits_written, results_seen);
    $display("By kind: method %0d path %0d name %0d value %0d header %0d end %0d body %0d %s%0d",
             kind_hits[K_METHOD], kind_hits[K_PATH], kind_hits[K_NAME], kind_hits[K_VALUE],
             kind_hits[K_HDONE], kind_hits[K_HEAD_END], kind_hits[K_BODY], "error ",
             kind_hits[K_ERROR]);
    if (errors == 0) begin
      $display("http_request_head_parser_unit test passed");
    end else begin
      $display("http_request_head_parser_unit test failed");
    end
    $finish;
  end

endmodule
